// ===== rtl/assert_macros.svh =====
// assertion helpers included by the frame engine
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when the trigger holds, the consequence must hold in the cycle after
`define ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ps2h_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2h_pkg
// shared types, codes and constants of the ps/2 host frame engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ps2h_pkg;

    localparam int unsigned RING_DEPTH_DEF = 16;

    // request codes
    typedef enum logic [1:0] {
        FUNC_EDGE = 2'd0,
        FUNC_SEND = 2'd1,
        FUNC_POP  = 2'd2
    } func_t;

    // sticky frame error codes
    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_START  = 2'd1,
        ERR_PARITY = 2'd2,
        ERR_STOP   = 2'd3
    } err_t;

    // receive frame positions, counted after the increment
    localparam logic [3:0] RX_START      = 4'd1;
    localparam logic [3:0] RX_DATA_FIRST = 4'd2;
    localparam logic [3:0] RX_DATA_LAST  = 4'd9;
    localparam logic [3:0] RX_PARITY     = 4'd10;

    // send frame positions, counted after the increment
    localparam logic [3:0] TX_DATA_FIRST = 4'd1;
    localparam logic [3:0] TX_DATA_LAST  = 4'd8;
    localparam logic [3:0] TX_PARITY     = 4'd9;
    localparam logic [3:0] TX_STOP       = 4'd10;

    typedef struct packed {
        logic [1:0] func;
        logic       clock_level;
        logic       data_line;
        logic [7:0] tx_byte;
    } in_word_t;

    typedef struct packed {
        logic       drive_data;
        logic       drive_enable;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       sending;
        logic       queue_nonempty;
        logic [1:0] last_error;
    } out_word_t;

endpackage

// ===== rtl/ps2h_stream_if.sv =====
// ----------------------------------------------------------------------------
// ps2h_stream_if
// valid/ready channel carrying one word per handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ps2h_stream_if #(
    parameter type word_t = ps2h_pkg::in_word_t
);

    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/ps2h_host_frame_engine.sv =====
// ----------------------------------------------------------------------------
// ps2_host_frame_engine: ps/2 host port frame engine with receive ring
// path: a request word's result word passes through stage one, then the output register
// throughput: one request word per cycle while the response side does not stall
// reset: control and indices clear at once; ring memory contents are not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ps2_host_frame_engine #(
    parameter int unsigned RING_DEPTH = ps2h_pkg::RING_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ps2h_stream_if.sink   req,
    ps2h_stream_if.source rsp
);

    import ps2h_pkg::*;

    // ring index width and wrap point
    localparam int unsigned    IDX_W    = $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

    // status computed at acceptance, held in stage one beside the registered ring read data
    typedef struct packed {
        logic       pop_hit;
        logic       drive_data;
        logic       drive_enable;
        logic       queue_nonempty;
        logic [1:0] last_error;
    } stage_t;

    // ------------------------------------------------------------------
    // frame state, kept in flops
    // ------------------------------------------------------------------
    logic [3:0]       rx_cnt_reg,   rx_cnt_next;
    logic [7:0]       rx_shift_reg, rx_shift_next;
    logic             rx_par_reg,   rx_par_next;
    logic             tx_active_reg, tx_active_next;
    logic [3:0]       tx_cnt_reg,   tx_cnt_next;
    logic [7:0]       tx_shift_reg, tx_shift_next;
    logic             tx_par_reg,   tx_par_next;
    logic             drive_reg,    drive_next;
    logic [IDX_W-1:0] wr_idx_reg,   wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg,   rd_idx_next;
    logic [1:0]       err_reg,      err_next;

    // ------------------------------------------------------------------
    // receive ring: synchronous memory, one write and one read port
    // ------------------------------------------------------------------
    logic [7:0]       ring_mem [RING_DEPTH];
    logic [7:0]       rd_data_reg;

    logic             accept;
    logic             push_en;
    logic             pop_en;
    logic [IDX_W-1:0] wr_inc;
    logic [IDX_W-1:0] rd_inc;
    logic [3:0]       rx_cnt_inc;
    logic [3:0]       tx_cnt_inc;

    // pipeline: stage one waits for the ring read, then the output register
    logic             s1_valid_reg;
    stage_t           s1_reg;
    stage_t           s1_next;
    logic             s1_adv;
    logic             out_valid_reg;
    out_word_t        out_reg;

    assign accept = req.valid && req.ready;

    // stage one moves on whenever the output register is empty or drained
    assign s1_adv    = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_adv;

    assign wr_inc     = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + 1'b1;
    assign rd_inc     = (rd_idx_reg == IDX_LAST) ? '0 : rd_idx_reg + 1'b1;
    assign rx_cnt_inc = rx_cnt_reg + 4'd1;
    assign tx_cnt_inc = tx_cnt_reg + 4'd1;

    // ------------------------------------------------------------------
    // next state of the frame logic for the accepted word
    // ------------------------------------------------------------------
    always_comb
    begin
        rx_cnt_next    = rx_cnt_reg;
        rx_shift_next  = rx_shift_reg;
        rx_par_next    = rx_par_reg;
        tx_active_next = tx_active_reg;
        tx_cnt_next    = tx_cnt_reg;
        tx_shift_next  = tx_shift_reg;
        tx_par_next    = tx_par_reg;
        drive_next     = drive_reg;
        rd_idx_next    = rd_idx_reg;
        err_next       = err_reg;
        push_en        = 1'b0;
        pop_en         = 1'b0;

        if (accept)
        begin
            case (req.data.func)
                FUNC_EDGE:
                begin
                    // only falling edges with the clock line low count
                    if (!req.data.clock_level)
                    begin
                        if (tx_active_reg)
                        begin
                            tx_cnt_next = tx_cnt_inc;
                            if (tx_cnt_inc inside {[TX_DATA_FIRST:TX_DATA_LAST]})
                            begin
                                // data bits go out lsb first
                                drive_next    = tx_shift_reg[0];
                                tx_par_next   = tx_par_reg ^ tx_shift_reg[0];
                                tx_shift_next = tx_shift_reg >> 1;
                            end
                            else if (tx_cnt_inc == TX_PARITY)
                            begin
                                drive_next = tx_par_reg;
                            end
                            else if (tx_cnt_inc == TX_STOP)
                            begin
                                drive_next = 1'b1;
                            end
                            else
                            begin
                                // ack edge: frame over, line released
                                tx_par_next    = 1'b1;
                                tx_cnt_next    = '0;
                                tx_active_next = 1'b0;
                                drive_next     = 1'b0;
                            end
                        end
                        else
                        begin
                            rx_cnt_next = rx_cnt_inc;
                            if (rx_cnt_inc == RX_START)
                            begin
                                if (req.data.data_line)
                                begin
                                    err_next      = ERR_START;
                                    rx_cnt_next   = '0;
                                    rx_shift_next = '0;
                                    rx_par_next   = 1'b1;
                                end
                            end
                            else if (rx_cnt_inc inside {[RX_DATA_FIRST:RX_DATA_LAST]})
                            begin
                                rx_shift_next = {req.data.data_line, rx_shift_reg[7:1]};
                                rx_par_next   = rx_par_reg ^ req.data.data_line;
                            end
                            else if (rx_cnt_inc == RX_PARITY)
                            begin
                                if (req.data.data_line != rx_par_reg)
                                begin
                                    err_next      = ERR_PARITY;
                                    rx_cnt_next   = '0;
                                    rx_shift_next = '0;
                                    rx_par_next   = 1'b1;
                                end
                            end
                            else
                            begin
                                // stop bit: good frames go to the ring unless it is full
                                if (!req.data.data_line)
                                    err_next = ERR_STOP;
                                else
                                    push_en = (wr_inc != rd_idx_reg);
                                rx_cnt_next   = '0;
                                rx_shift_next = '0;
                                rx_par_next   = 1'b1;
                            end
                        end
                    end
                end
                FUNC_SEND:
                begin
                    // host pulls data low for the start bit right away
                    tx_shift_next  = req.data.tx_byte;
                    tx_active_next = 1'b1;
                    tx_cnt_next    = '0;
                    tx_par_next    = 1'b1;
                    drive_next     = 1'b0;
                end
                FUNC_POP:
                begin
                    if (wr_idx_reg != rd_idx_reg)
                    begin
                        pop_en      = 1'b1;
                        rd_idx_next = rd_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end

        wr_idx_next = push_en ? wr_inc : wr_idx_reg;

        // status as it stands after this word
        s1_next.pop_hit        = pop_en;
        s1_next.drive_data     = tx_active_next & drive_next;
        s1_next.drive_enable   = tx_active_next;
        s1_next.queue_nonempty = (wr_idx_next != rd_idx_next);
        s1_next.last_error     = err_next;
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_cnt_reg    <= '0;
            rx_shift_reg  <= '0;
            rx_par_reg    <= 1'b1;
            tx_active_reg <= 1'b0;
            tx_cnt_reg    <= '0;
            tx_shift_reg  <= '0;
            tx_par_reg    <= 1'b1;
            drive_reg     <= 1'b0;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            err_reg       <= ERR_NONE;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rx_cnt_reg    <= rx_cnt_next;
            rx_shift_reg  <= rx_shift_next;
            rx_par_reg    <= rx_par_next;
            tx_active_reg <= tx_active_next;
            tx_cnt_reg    <= tx_cnt_next;
            tx_shift_reg  <= tx_shift_next;
            tx_par_reg    <= tx_par_next;
            drive_reg     <= drive_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            err_reg       <= err_next;

            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // ring memory; push and pop come from different words, so a read never
    // meets a write to the same entry in one cycle and needs no bypass
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (push_en)
            ring_mem[wr_idx_reg] <= rx_shift_reg;
        // read data holds until the next pop, which keeps it through a stall
        if (pop_en)
            rd_data_reg <= ring_mem[rd_idx_reg];
    end

    // ------------------------------------------------------------------
    // pipeline payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
        if (s1_adv && s1_valid_reg)
        begin
            out_reg.drive_data     <= s1_reg.drive_data;
            out_reg.drive_enable   <= s1_reg.drive_enable;
            out_reg.rx_byte        <= s1_reg.pop_hit ? rd_data_reg : 8'h00;
            out_reg.rx_valid       <= s1_reg.pop_hit;
            out_reg.sending        <= s1_reg.drive_enable;
            out_reg.queue_nonempty <= s1_reg.queue_nonempty;
            out_reg.last_error     <= s1_reg.last_error;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a stalled stage one keeps its status and the popped byte it waits on
    `ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_reg) && $stable(rd_data_reg), "stage one lost its word or ring data during a stall")
    // a send frame never counts past the stop bit
    `ASSERT_ALWAYS(a_tx_count, !tx_active_reg || (tx_cnt_reg <= TX_STOP), "send bit count out of range")
    // with no send frame the data line is released and the counter is idle
    `ASSERT_ALWAYS(a_tx_idle, tx_active_reg || ((tx_cnt_reg == 4'd0) && !drive_reg), "idle sender still drives or counts")

endmodule
